// File: sv/u8s_pkg.sv
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types and constants for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

  // Request codes on req_type.
  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Bytes of the replacement character U+FFFD.
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Job queue between the decoder and the byte emitter.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One job: repl_cnt replacements, then raw_cnt raw bytes, then an
  // optional terminating zero.
  typedef struct packed {
    logic [2:0]      repl_cnt;
    logic [2:0]      raw_cnt;
    logic [3:0][7:0] raw;
    logic            term;
  } job_t;

endpackage

// File: sv/u8s_front.sv
// ----------------------------------------------------------------------------
// u8s_front
// Accepts text and end requests, tracks the open sequence and pushes a job
// for the emitter on each transaction that has bytes to emit.
// ----------------------------------------------------------------------------
module u8s_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic          req_type,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          push,
  output u8s_pkg::job_t job
);
  import u8s_pkg::*;

  logic [7:0] held_bytes [3];
  logic [1:0] held_count, held_count_next;
  logic [2:0] seq_len, seq_len_next;
  logic       accept;
  logic       is_ascii, is_lead, fits, fresh;
  logic       st_lead, st_cont;
  logic [2:0] lead_len;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;

  always_comb begin
    is_ascii = data_byte < 8'h80;
    is_lead  = (data_byte >= 8'hC2) && (data_byte <= 8'hF4);
    if (data_byte <= 8'hDF) begin
      lead_len = 3'd2;
    end else if (data_byte <= 8'hEF) begin
      lead_len = 3'd3;
    end else begin
      lead_len = 3'd4;
    end

    // The second byte of some sequences has a narrower range.
    fits = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
    if (held_count == 2'd1) begin
      case (held_bytes[0])
        8'hE0:   if (data_byte < 8'hA0) fits = 1'b0;
        8'hED:   if (data_byte > 8'h9F) fits = 1'b0;
        8'hF0:   if (data_byte < 8'h90) fits = 1'b0;
        8'hF4:   if (data_byte > 8'h8F) fits = 1'b0;
        default: ;
      endcase
    end

    job             = '0;
    held_count_next = held_count;
    seq_len_next    = seq_len;
    st_lead         = 1'b0;
    st_cont         = 1'b0;
    fresh           = 1'b0;

    if (req_type == REQ_END) begin
      job.repl_cnt    = {1'b0, held_count};
      job.term        = 1'b1;
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end else if (held_count == 2'd0) begin
      fresh = 1'b1;
    end else if (fits) begin
      if (({1'b0, held_count} + 3'd1) >= seq_len) begin
        for (int i = 0; i < 3; i++) begin
          job.raw[i] = (i < int'(held_count)) ? held_bytes[i] : data_byte;
        end
        job.raw[3]      = data_byte;
        job.raw_cnt     = {1'b0, held_count} + 3'd1;
        held_count_next = 2'd0;
        seq_len_next    = 3'd0;
      end else begin
        st_cont         = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // Broken sequence: every held byte is replaced, then the byte is
      // decoded as if nothing were held.
      job.repl_cnt    = {1'b0, held_count};
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      fresh           = 1'b1;
    end

    if (fresh) begin
      if (is_ascii) begin
        job.raw[0]  = data_byte;
        job.raw_cnt = 3'd1;
      end else if (is_lead) begin
        st_lead         = 1'b1;
        held_count_next = 2'd1;
        seq_len_next    = lead_len;
      end else begin
        job.repl_cnt = job.repl_cnt + 3'd1;
      end
    end

    push = accept && ((job.repl_cnt != 3'd0) || (job.raw_cnt != 3'd0) || job.term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len    <= 3'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      seq_len    <= seq_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && st_lead) begin
      held_bytes[0] <= data_byte;
    end
    if (accept && st_cont) begin
      held_bytes[held_count] <= data_byte;
    end
  end

endmodule

// File: sv/u8s_fifo.sv
// ----------------------------------------------------------------------------
// u8s_fifo
// Short job queue that lets the decoder and the emitter stall separately.
// ----------------------------------------------------------------------------
module u8s_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u8s_pkg::job_t wr_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output u8s_pkg::job_t head
);
  import u8s_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/u8s_back.sv
// ----------------------------------------------------------------------------
// u8s_back
// Expands queued jobs into output bytes, one per cycle while rsp_stall does not
// hold it, into a registered output stage.
// ----------------------------------------------------------------------------
module u8s_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  u8s_pkg::job_t q_head,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          text_done
);
  import u8s_pkg::*;

  logic            busy;
  logic [2:0]      rep_left;
  logic [1:0]      sub;
  logic [2:0]      raw_pos;
  logic [2:0]      raw_cnt;
  logic [3:0][7:0] raw;
  logic            term;

  logic       out_free, emit, is_last, cur_done;
  logic [7:0] cur_byte;

  always_comb begin
    out_free = !rsp_valid || !rsp_stall;
    emit     = busy && out_free;
    cur_done = 1'b0;
    if (rep_left != 3'd0) begin
      case (sub)
        2'd0:    cur_byte = REPL_B0;
        2'd1:    cur_byte = REPL_B1;
        default: cur_byte = REPL_B2;
      endcase
      is_last = (rep_left == 3'd1) && (sub == 2'd2) && (raw_cnt == 3'd0) && !term;
    end else if (raw_pos < raw_cnt) begin
      cur_byte = raw[raw_pos[1:0]];
      is_last  = ((raw_pos + 3'd1) == raw_cnt) && !term;
    end else begin
      cur_byte = 8'h00;
      cur_done = 1'b1;
      is_last  = 1'b1;
    end
    pop = !q_empty && (!busy || (emit && is_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_free) begin
        rsp_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rep_left <= q_head.repl_cnt;
      sub      <= 2'd0;
      raw_pos  <= 3'd0;
      raw_cnt  <= q_head.raw_cnt;
      raw      <= q_head.raw;
      term     <= q_head.term;
    end else if (emit) begin
      if (rep_left != 3'd0) begin
        if (sub == 2'd2) begin
          sub      <= 2'd0;
          rep_left <= rep_left - 3'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end else if (raw_pos < raw_cnt) begin
        raw_pos <= raw_pos + 3'd1;
      end
    end
    if (emit) begin
      out_byte  <= cur_byte;
      run_last  <= is_last;
      text_done <= cur_done;
    end
  end

endmodule

// File: sv/utf8_sanitizer_unit.sv
// A transaction's job passes the job queue and the emitter's registers into the
// registered output stage. Throughput: one byte out per cycle while rsp_stall
// does not hold the output, so one input byte per cycle for valid text; a job
// of up to twelve bytes holds the emitter until expanded, and the four-entry
// job queue stalls the input once it fills. Reset clears the decode state, the
// job queue and the output stage; nothing else needs a clearing pass.
// ----------------------------------------------------------------------------
// utf8_sanitizer_unit
// Streaming UTF-8 validator that replaces malformed input with U+FFFD.
// ----------------------------------------------------------------------------
module utf8_sanitizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_done
);
  import u8s_pkg::*;

  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  u8s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  u8s_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (head_job)
  );

  u8s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_done (text_done)
  );

  // The terminator is a zero byte and always closes its transaction.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && text_done |-> (out_byte == 8'h00) && run_last)
    else $error("terminator is not a final zero byte");

  // The front stalls on a full queue, so it never pushes into one.
  assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("job queue overflow");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk) disable iff (rst) !(pop && q_empty))
    else $error("job queue underflow");

  // Right after reset the output stage is empty.
  assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("output valid after reset");

endmodule
